// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== src/ssnf_pkg.sv =====
// Constants, segment table and helpers of the seven-segment number formatter.
package ssnf_pkg;

	// Field widths.
	localparam int VAL_W   = 32;
	localparam int RADIX_W = 5;
	localparam int SEG_W   = 8;

	// Digit places available to a nonnegative value.
	localparam int NUM_DIGITS = 4;
	// Digit positions on the display (the colon is not one of them).
	localparam int DISP_SLOTS = 4;
	localparam int SLOT_N     = (NUM_DIGITS > DISP_SLOTS) ? NUM_DIGITS : DISP_SLOTS;
	localparam int IDX_W      = $clog2(SLOT_N);
	localparam int CNT_W      = $clog2(NUM_DIGITS + 1);

	// Divider: quotient bits retired per cycle and cycles per digit.
	localparam int DIGIT_BITS = 4;
	localparam int DIV_CYC    = VAL_W / DIGIT_BITS;
	localparam int CYC_W      = $clog2(DIV_CYC);
	// Remainder stays below the radix, at most 15.
	localparam int REM_W      = 4;

	// Valid radix range.
	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

	// Special segment patterns.
	localparam logic [SEG_W-1:0] MINUS_SEG = 8'h40;
	localparam logic [SEG_W-1:0] BLANK_SEG = 8'h00;

	// Hex digit to segment pattern.
	function automatic logic [SEG_W-1:0] seg_of(input logic [REM_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'h0: s = 8'h3F;
			4'h1: s = 8'h06;
			4'h2: s = 8'h5B;
			4'h3: s = 8'h4F;
			4'h4: s = 8'h66;
			4'h5: s = 8'h6D;
			4'h6: s = 8'h7D;
			4'h7: s = 8'h07;
			4'h8: s = 8'h7F;
			4'h9: s = 8'h6F;
			4'hA: s = 8'h77;
			4'hB: s = 8'h7C;
			4'hC: s = 8'h39;
			4'hD: s = 8'h5E;
			4'hE: s = 8'h79;
			4'hF: s = 8'h71;
			default: s = BLANK_SEG;
		endcase
		return s;
	endfunction

endpackage

// ===== src/seven_segment_number_formatter.sv =====
// Top level of the seven-segment number formatter.
// Converts a signed 32-bit value to the segment bytes of a four-digit display with a
// colon in the middle position, in any radix from 2 to 16. Digits are produced low
// first by a restoring divider that retires four quotient bits a cycle; conversion
// stops as soon as the quotient reaches zero. The next item is accepted the cycle
// after the result is loaded into the output register, so no new item is taken while
// one is being converted or waits to be loaded. A value whose magnitude needs more
// digits than the display offers (three when negative), or a radix outside 2..16,
// shows dashes in all four digit positions and raises overflow.
module seven_segment_number_formatter
	import ssnf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [VAL_W-1:0]   value,
	input  logic        [RADIX_W-1:0] radix,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic        [SEG_W-1:0]   seg_pos0,
	output logic        [SEG_W-1:0]   seg_pos1,
	output logic        [SEG_W-1:0]   seg_colon,
	output logic        [SEG_W-1:0]   seg_pos3,
	output logic        [SEG_W-1:0]   seg_pos4,
	output logic                      overflow
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_FIN
	} state_t;

	state_t               state_q;
	logic [CYC_W-1:0]     cyc_q;
	logic [CNT_W-1:0]     dig_cnt_q;
	logic                 qnz_q;
	logic                 neg_q;
	logic                 err_q;
	logic                 out_valid_q;
	logic [SEG_W-1:0]     pos0_q, pos1_q, pos3_q, pos4_q;
	logic                 overflow_q;

	logic [VAL_W-1:0]     mag_q;
	logic [RADIX_W-1:0]   rad_q;
	logic [REM_W-1:0]     rem_q;
	logic [SEG_W-1:0]     digit_q [SLOT_N];

	logic                 accept;
	logic [VAL_W-1:0]     val_u;
	logic [VAL_W-1:0]     mag_in;
	logic                 radix_ok;
	logic [DIGIT_BITS-1:0] qn;
	logic [REM_W-1:0]     rem_v;
	logic [VAL_W-1:0]     mag_nxt;
	logic                 qnz_nxt;
	logic                 digit_done;
	logic [CNT_W-1:0]     places;
	logic [CNT_W-1:0]     dig_cnt_nxt;
	logic                 load_out;
	logic [SEG_W-1:0]     place_seg [DISP_SLOTS];

	// Handshake on the input side: items are taken only while idle.
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// Magnitude and radix check of the incoming item.
	assign val_u    = value;
	assign mag_in   = val_u[VAL_W-1] ? (VAL_W'(0) - val_u) : val_u;
	assign radix_ok = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);

	// One divider step: four restoring compare-and-subtract stages on the narrow remainder.
	always_comb begin
		logic [REM_W:0] r;
		rem_v = rem_q;
		qn    = '0;
		for (int i = 0; i < DIGIT_BITS; i++) begin
			r = {rem_v, mag_q[VAL_W-1-i]};
			if (r >= rad_q) begin
				r = r - rad_q;
				qn[DIGIT_BITS-1-i] = 1'b1;
			end
			rem_v = r[REM_W-1:0];
		end
	end

	assign mag_nxt     = {mag_q[VAL_W-DIGIT_BITS-1:0], qn};
	assign qnz_nxt     = qnz_q || (|qn);
	assign digit_done  = (cyc_q == CYC_W'(DIV_CYC - 1));
	assign places      = neg_q ? CNT_W'(NUM_DIGITS - 1) : CNT_W'(NUM_DIGITS);
	assign dig_cnt_nxt = dig_cnt_q + CNT_W'(1);

	// Display places right to left: digits, then a minus for negative values, then blanks.
	always_comb begin
		for (int p = 0; p < DISP_SLOTS; p++) begin
			if (CNT_W'(p) < dig_cnt_q) begin
				place_seg[p] = digit_q[p];
			end else if (neg_q && (CNT_W'(p) == dig_cnt_q)) begin
				place_seg[p] = MINUS_SEG;
			end else begin
				place_seg[p] = BLANK_SEG;
			end
		end
	end

	// The output register takes a new result when it is empty or being emptied.
	assign load_out = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cyc_q       <= '0;
			dig_cnt_q   <= '0;
			qnz_q       <= 1'b0;
			neg_q       <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
			pos0_q      <= BLANK_SEG;
			pos1_q      <= BLANK_SEG;
			pos3_q      <= BLANK_SEG;
			pos4_q      <= BLANK_SEG;
			overflow_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						neg_q     <= val_u[VAL_W-1];
						err_q     <= !radix_ok;
						cyc_q     <= '0;
						dig_cnt_q <= '0;
						qnz_q     <= 1'b0;
						state_q   <= radix_ok ? S_DIV : S_FIN;
					end
				end
				S_DIV: begin
					if (digit_done) begin
						cyc_q     <= '0;
						qnz_q     <= 1'b0;
						dig_cnt_q <= dig_cnt_nxt;
						if (!qnz_nxt) begin
							state_q <= S_FIN;
						end else if (dig_cnt_nxt == places) begin
							err_q   <= 1'b1;
							state_q <= S_FIN;
						end
					end else begin
						cyc_q <= cyc_q + CYC_W'(1);
						qnz_q <= qnz_nxt;
					end
				end
				S_FIN: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						overflow_q  <= err_q;
						if (err_q) begin
							pos0_q <= MINUS_SEG;
							pos1_q <= MINUS_SEG;
							pos3_q <= MINUS_SEG;
							pos4_q <= MINUS_SEG;
						end else begin
							pos4_q <= place_seg[0];
							pos3_q <= place_seg[1];
							pos1_q <= place_seg[2];
							pos0_q <= place_seg[3];
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Divider datapath and digit store.
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag_in;
			rad_q <= radix;
			rem_q <= '0;
		end else if (state_q == S_DIV) begin
			mag_q <= mag_nxt;
			rem_q <= digit_done ? '0 : rem_v;
			if (digit_done) begin
				digit_q[dig_cnt_q[IDX_W-1:0]] <= seg_of(rem_v);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign seg_pos0  = pos0_q;
	assign seg_pos1  = pos1_q;
	assign seg_colon = BLANK_SEG;
	assign seg_pos3  = pos3_q;
	assign seg_pos4  = pos4_q;
	assign overflow  = overflow_q;

endmodule

// ===== src/ssnf_checker.sv =====
// Port-level checker of the seven-segment number formatter and its bind.
`include "assert_macros.svh"

module ssnf_checker
	import ssnf_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic        [SEG_W-1:0]   seg_pos0,
	input logic        [SEG_W-1:0]   seg_pos1,
	input logic        [SEG_W-1:0]   seg_colon,
	input logic        [SEG_W-1:0]   seg_pos3,
	input logic        [SEG_W-1:0]   seg_pos4,
	input logic                      overflow
);

	logic [5*SEG_W:0] shown;
	logic             all_dash;

	// Whole result as seen on the port, and the dash pattern test.
	assign shown    = {seg_pos0, seg_pos1, seg_colon, seg_pos3, seg_pos4, overflow};
	assign all_dash = (seg_pos0 == MINUS_SEG) && (seg_pos1 == MINUS_SEG) &&
	                  (seg_pos3 == MINUS_SEG) && (seg_pos4 == MINUS_SEG);

	// A result that is held back stays on the port unchanged.
	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(shown))

	// Once an item is taken, the block is busy on the following cycle.
	`ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// The colon position is never lit.
	`ASSERT_IMP(a_colon_blank, clk, arst_n, out_valid, seg_colon == BLANK_SEG)

	// The error pattern fills all four digit positions with dashes.
	`ASSERT_IMP(a_err_pattern, clk, arst_n, out_valid && overflow, all_dash)

	// A number always shows at least one digit in the rightmost position.
	`ASSERT_IMP(a_digit_shown, clk, arst_n, out_valid && !overflow, seg_pos4 != BLANK_SEG && seg_pos4 != MINUS_SEG)

endmodule

bind seven_segment_number_formatter ssnf_checker u_ssnf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.seg_pos0  (seg_pos0),
	.seg_pos1  (seg_pos1),
	.seg_colon (seg_colon),
	.seg_pos3  (seg_pos3),
	.seg_pos4  (seg_pos4),
	.overflow  (overflow)
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the seven-segment number formatter.
`timescale 1ns / 100ps

module tb_top;
	import ssnf_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PHASE_ITEMS    = 156;

	// Glyphs of hex digits 0..F, digit 0 in the low byte.
	localparam logic [16*SEG_W-1:0] HEX_GLYPHS = {
		8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
		8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
	};

	typedef struct packed {
		logic [SEG_W-1:0] p0;
		logic [SEG_W-1:0] p1;
		logic [SEG_W-1:0] colon;
		logic [SEG_W-1:0] p3;
		logic [SEG_W-1:0] p4;
		logic             ovf;
	} display_t;

	typedef struct {
		logic [VAL_W-1:0]   number;
		logic [RADIX_W-1:0] base;
		display_t           shown;
	} pending_display_t;

	// Scoreboard: predicts the display of each accepted item and checks results in order.
	class segment_scoreboard;
		pending_display_t expected_displays[$];
		int mismatch_cnt;
		int checked_cnt;
		int error_pattern_cnt;

		function display_t format_number(logic [VAL_W-1:0] raw, logic [RADIX_W-1:0] base);
			logic [SEG_W-1:0] slot_seg [5];
			logic             neg;
			logic [VAL_W-1:0] mag;
			int               places;
			longint unsigned  bound;
			bit               err;
			int               slot;
			display_t         d;
			neg    = raw[VAL_W-1];
			mag    = neg ? (~raw + 1'b1) : raw;
			places = NUM_DIGITS - (neg ? 1 : 0);
			err    = (base < RADIX_MIN) || (base > RADIX_MAX);
			if (!err) begin
				bound = 1;
				for (int i = 0; i < places; i++)
					bound = bound * base;
				if (longint'(mag) >= bound)
					err = 1'b1;
			end
			for (int i = 0; i < 5; i++)
				slot_seg[i] = BLANK_SEG;
			if (err) begin
				slot_seg[0] = MINUS_SEG;
				slot_seg[1] = MINUS_SEG;
				slot_seg[3] = MINUS_SEG;
				slot_seg[4] = MINUS_SEG;
			end else begin
				// Fill digits from the right, jumping over the colon slot.
				slot = 4;
				if (mag == 0) begin
					slot_seg[slot] = HEX_GLYPHS[0 +: SEG_W];
					slot--;
				end else begin
					while (mag != 0) begin
						if (slot >= 0)
							slot_seg[slot] = HEX_GLYPHS[(mag % base) * SEG_W +: SEG_W];
						slot--;
						if (slot == 2)
							slot--;
						mag = mag / base;
					end
				end
				if (neg && slot >= 0)
					slot_seg[slot] = MINUS_SEG;
			end
			d.p0    = slot_seg[0];
			d.p1    = slot_seg[1];
			d.colon = BLANK_SEG;
			d.p3    = slot_seg[3];
			d.p4    = slot_seg[4];
			d.ovf   = err;
			return d;
		endfunction

		function void note_input(logic [VAL_W-1:0] number, logic [RADIX_W-1:0] base);
			pending_display_t e;
			e.number = number;
			e.base   = base;
			e.shown  = format_number(number, base);
			expected_displays.push_back(e);
		endfunction

		function void check_result(display_t got);
			pending_display_t e;
			if (expected_displays.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: result %h with no item outstanding", $realtime, got);
				return;
			end
			e = expected_displays.pop_front();
			checked_cnt++;
			if (e.shown.ovf)
				error_pattern_cnt++;
			if (got.p0 !== e.shown.p0 || got.p1 !== e.shown.p1 ||
			    got.colon !== e.shown.colon || got.p3 !== e.shown.p3 ||
			    got.p4 !== e.shown.p4 || got.ovf !== e.shown.ovf) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: value %h radix %0d: expected %h %h %h %h %h ovf %b, got %h %h %h %h %h ovf %b",
						$realtime, e.number, e.base,
						e.shown.p0, e.shown.p1, e.shown.colon, e.shown.p3, e.shown.p4, e.shown.ovf,
						got.p0, got.p1, got.colon, got.p3, got.p4, got.ovf);
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	logic signed [VAL_W-1:0]   value     = '0;
	logic        [RADIX_W-1:0] radix     = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic        [SEG_W-1:0]   seg_pos0;
	logic        [SEG_W-1:0]   seg_pos1;
	logic        [SEG_W-1:0]   seg_colon;
	logic        [SEG_W-1:0]   seg_pos3;
	logic        [SEG_W-1:0]   seg_pos4;
	logic                      overflow;

	segment_scoreboard sb = new();

	int send_idle_pct  = 0;
	int stall_pct      = 0;
	int hold_reqs      = 0;
	int items_sent     = 0;
	int directed_items = 0;
	int quiet_cycles   = 0;

	seven_segment_number_formatter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.radix     (radix),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.seg_pos0  (seg_pos0),
		.seg_pos1  (seg_pos1),
		.seg_colon (seg_colon),
		.seg_pos3  (seg_pos3),
		.seg_pos4  (seg_pos4),
		.overflow  (overflow)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Monitor both channels and watch for a hung block.
	always @(posedge clk) begin
		display_t got;
		logic     took_in;
		logic     took_out;
		took_in  = arst_n && in_valid && !in_stall;
		took_out = arst_n && out_valid && !out_stall;
		if (took_in)
			sb.note_input(value, radix);
		if (took_out) begin
			got.p0    = seg_pos0;
			got.p1    = seg_pos1;
			got.colon = seg_colon;
			got.p3    = seg_pos3;
			got.p4    = seg_pos4;
			got.ovf   = overflow;
			sb.check_result(got);
		end
		if (arst_n) begin
			if (took_in || took_out) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
		end
	end

	// Offer one item after a random gap and hold it until the block takes it.
	task automatic send_item(input logic [VAL_W-1:0] number, input logic [RADIX_W-1:0] base);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= number;
		radix    <= base;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
	endtask

	// Stop offering and wait until every expected display has come back.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_displays.size() != 0);
	endtask

	// Pick a value for the given radix: mostly near or inside the displayable range.
	function automatic logic [VAL_W-1:0] pick_value(logic [RADIX_W-1:0] base);
		int               kind;
		bit               neg;
		int               places;
		int unsigned      bound;
		logic [VAL_W-1:0] mag;
		kind = $urandom_range(9);
		neg  = 1'($urandom_range(1));
		if (base < RADIX_MIN || base > RADIX_MAX || kind < 2)
			return $urandom;
		places = NUM_DIGITS - (neg ? 1 : 0);
		bound  = 1;
		for (int i = 0; i < places; i++)
			bound = bound * base;
		case (kind)
			2, 3, 4, 5: mag = $urandom_range(bound - 1, 0);
			6, 7:       mag = bound - 1 + $urandom_range(2);
			8:          mag = $urandom_range(base, 0);
			default: begin
				case ($urandom_range(3))
					0:       return '0;
					1:       return '1;
					2:       return 32'h7FFF_FFFF;
					default: return 32'h8000_0000;
				endcase
			end
		endcase
		return neg ? (~mag + 1'b1) : mag;
	endfunction

	task automatic send_random_item();
		logic [RADIX_W-1:0] base;
		if ($urandom_range(9) == 0)
			base = RADIX_W'($urandom_range(31));
		else
			base = RADIX_W'($urandom_range(RADIX_MAX, RADIX_MIN));
		send_item(pick_value(base), base);
	endtask

	// Main sequence.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items: zero, range edges in several radixes, every hex glyph,
		// the most negative value and each kind of bad radix.
		send_item(32'sd0, 5'd10);
		send_item(32'sd1, 5'd10);
		send_item(32'sd9999, 5'd10);
		send_item(32'sd10000, 5'd10);
		send_item(-32'sd1, 5'd10);
		send_item(-32'sd999, 5'd10);
		send_item(-32'sd1000, 5'd10);
		send_item(32'h0000_1234, 5'd16);
		send_item(32'h0000_5678, 5'd16);
		send_item(32'h0000_9ABC, 5'd16);
		send_item(32'h0000_DEF0, 5'd16);
		send_item(32'h0001_0000, 5'd16);
		send_item(-32'sh0FFF, 5'd16);
		send_item(32'h7FFF_FFFF, 5'd16);
		send_item(32'h8000_0000, 5'd16);
		send_item(32'sd15, 5'd2);
		send_item(32'sd16, 5'd2);
		send_item(-32'sd7, 5'd2);
		send_item(-32'sd8, 5'd2);
		send_item(32'sd80, 5'd3);
		send_item(32'sd81, 5'd3);
		send_item(32'sd5, 5'd0);
		send_item(32'sd5, 5'd1);
		send_item(32'sd5, 5'd17);
		send_item(32'sd5, 5'd31);
		directed_items = items_sent;
		wait_for_results();

		// Random items under four idling patterns.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct <= 0;  end
				1: begin send_idle_pct = 51; stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  stall_pct <= 51; end
				default: begin send_idle_pct = 8; stall_pct <= 8; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Long receiver hold-off while items keep being offered.
				if (phase == 0 && n == 40)
					hold_reqs <= hold_reqs + 1;
				// Sender pause until the block has emptied.
				if (n == 100)
					wait_for_results();
				send_random_item();
			end
			wait_for_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d items (%0d directed), %0d results checked, %0d with dashes.",
			items_sent, directed_items, sb.checked_cnt, sb.error_pattern_cnt);
		$display("Idling: none, sender 51%%, receiver 51%%, both 8%%; one %0d-cycle hold-off.",
			HOLD_CYCLES);
		if (sb.mismatch_cnt == 0 && sb.expected_displays.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatch_cnt,
				sb.expected_displays.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/ssnf_pkg.sv
src/seven_segment_number_formatter.sv
src/ssnf_checker.sv
bench/tb_top.sv
